/* rtl/mlc_pkg.sv */
// mlc_pkg: shared constants and register index codes for the mu-law compressor.
// No dependencies; imported by every rtl/mlc_* module and by the top level.
package mlc_pkg;

  localparam int FRAC_BITS_DEF = 16;   // default fraction bits of level and result
  localparam int MANT_BITS     = 30;   // mantissa fraction bits, Q1.30
  localparam int MU_W          = 16;
  localparam int NORM_W        = 17;
  localparam int SCALE_BITS    = 16;   // norm_scale is Q1.16
  localparam int IPART_W       = 5;    // integer part of log2, 0..16
  localparam int CFG_IDX_W     = 2;

  localparam logic [MU_W-1:0]   MU_RST   = 16'd255;
  localparam logic [NORM_W-1:0] NORM_RST = 17'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MU         = 2'd0,
    CFG_NORM_SCALE = 2'd1
  } cfg_idx_t;

endpackage

/* rtl/mlc_front.sv */
// mlc_front: clamp, a = 1 + mu*d, then leading-one detect and normalize to Q1.30.
// Two register stages. Depends on mlc_pkg.
module mlc_front import mlc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [FRAC_BITS:0]       level_i,
  input  logic [MU_W-1:0]          mu_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [IPART_W-1:0]       ipart_o,
  output logic [MANT_BITS:0]       mant_o
);

  localparam int AW = FRAC_BITS + MU_W + 1;   // width of a = 1 + mu*d
  localparam int PW = $clog2(AW);
  localparam int EW = AW + MANT_BITS + 1;

  logic                 va_r, vb_r;
  logic                 adv_a, adv_b;
  logic [FRAC_BITS:0]   d_c;
  logic [AW-1:0]        a_nxt, a_r;
  logic [PW-1:0]        p;
  logic [PW-1:0]        sh;
  logic [EW-1:0]        ext;
  logic [IPART_W-1:0]   ipart_nxt, ipart_r;
  logic [MANT_BITS:0]   mant_nxt, mant_r;

  assign adv_b   = !vb_r || ready_i;
  assign adv_a   = !va_r || adv_b;
  assign ready_o = adv_a;

  // Saturate the level at 1.0
  assign d_c   = (level_i > {1'b1, {FRAC_BITS{1'b0}}}) ? {1'b1, {FRAC_BITS{1'b0}}} : level_i;
  assign a_nxt = ({{(FRAC_BITS+1){1'b0}}, mu_i} * {{MU_W{1'b0}}, d_c})
               + (AW'(1) << FRAC_BITS);

  // a >= 1.0, so a one is always found
  always_comb begin
    p = '0;
    for (int i = 0; i < AW; i++) begin
      if (a_r[i]) p = PW'(i);
    end
  end

  assign sh        = PW'(AW - 1) - p;
  assign ext       = {a_r, {(MANT_BITS+1){1'b0}}} << sh;
  assign mant_nxt  = ext[EW-1 -: MANT_BITS+1];
  assign ipart_nxt = IPART_W'(p - PW'(FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= valid_i;
      if (adv_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && valid_i) a_r <= a_nxt;
    if (adv_b && va_r) begin
      ipart_r <= ipart_nxt;
      mant_r  <= mant_nxt;
    end
  end

  assign valid_o = vb_r;
  assign ipart_o = ipart_r;
  assign mant_o  = mant_r;

endmodule

/* rtl/mlc_log_pipe.sv */
// mlc_log_pipe: FRAC_BITS squaring stages, one fraction bit of log2 per stage.
// Depends on mlc_pkg.
module mlc_log_pipe import mlc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [IPART_W-1:0]     ipart_i,
  input  logic [MANT_BITS:0]     mant_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [IPART_W-1:0]     ipart_o,
  output logic [FRAC_BITS-1:0]   frac_o
);

  localparam int MW = MANT_BITS + 1;

  logic [FRAC_BITS-1:0]  valid_r;
  logic [FRAC_BITS:0]    adv;
  logic [IPART_W-1:0]    ipart_r [FRAC_BITS];
  logic [FRAC_BITS-1:0]  frac_r  [FRAC_BITS];
  logic [MW-1:0]         mant_r  [FRAC_BITS-1];

  assign adv[FRAC_BITS] = ready_i;
  assign ready_o        = adv[0];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic                 v_src;
    logic [IPART_W-1:0]   ip_src;
    logic [FRAC_BITS-1:0] fr_src;
    logic [MW-1:0]        m_src;
    logic [2*MW-1:0]      sq;
    logic [MW:0]          t;

    if (k == 0) begin : g_first
      assign v_src  = valid_i;
      assign ip_src = ipart_i;
      assign fr_src = '0;
      assign m_src  = mant_i;
    end else begin : g_next
      assign v_src  = valid_r[k-1];
      assign ip_src = ipart_r[k-1];
      assign fr_src = frac_r[k-1];
      assign m_src  = mant_r[k-1];
    end

    assign adv[k] = !valid_r[k] || adv[k+1];
    assign sq     = {{MW{1'b0}}, m_src} * {{MW{1'b0}}, m_src};
    assign t      = sq[2*MANT_BITS+1 -: MW+1];   // Q2.30, truncated

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv[k]) begin
        valid_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && v_src) begin
        ipart_r[k] <= ip_src;
        frac_r[k]  <= {fr_src[FRAC_BITS-2:0], t[MW]};
      end
    end

    if (k < FRAC_BITS - 1) begin : g_mant
      always_ff @(posedge clk) begin
        if (adv[k] && v_src) begin
          mant_r[k] <= t[MW] ? t[MW:1] : t[MW-1:0];
        end
      end
    end
  end

  assign valid_o = valid_r[FRAC_BITS-1];
  assign ipart_o = ipart_r[FRAC_BITS-1];
  assign frac_o  = frac_r[FRAC_BITS-1];

endmodule

/* rtl/mlc_scale.sv */
// mlc_scale: log2 times norm_scale, then saturation at 1.0 into the output register.
// Two register stages. Depends on mlc_pkg.
module mlc_scale import mlc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [IPART_W-1:0]     ipart_i,
  input  logic [FRAC_BITS-1:0]   frac_i,
  input  logic [NORM_W-1:0]      norm_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [FRAC_BITS:0]     result_o
);

  localparam int LW  = IPART_W + FRAC_BITS;
  localparam int PRW = LW + NORM_W;
  localparam int YW  = PRW - SCALE_BITS;

  logic                 vc_r, vd_r;
  logic                 adv_c, adv_d;
  logic [PRW-1:0]       prod_nxt, prod_r;
  logic [YW-1:0]        y;
  logic [FRAC_BITS:0]   res_nxt, res_r;

  assign adv_d   = !vd_r || ready_i;
  assign adv_c   = !vc_r || adv_d;
  assign ready_o = adv_c;

  assign prod_nxt = {{NORM_W{1'b0}}, ipart_i, frac_i} * {{LW{1'b0}}, norm_i};
  assign y        = prod_r[PRW-1:SCALE_BITS];
  assign res_nxt  = (y > (YW'(1) << FRAC_BITS)) ? {1'b1, {FRAC_BITS{1'b0}}} : y[FRAC_BITS:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_c) vc_r <= valid_i;
      if (adv_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && valid_i) prod_r <= prod_nxt;
    if (adv_d && vc_r)    res_r  <= res_nxt;
  end

  assign valid_o  = vd_r;
  assign result_o = res_r;

endmodule

/* rtl/mu_law_compressor_core.sv */
// mu_law_compressor_core: continuous mu-law compressor, y = log2(1+mu*d) * norm_scale.
// Depends on mlc_pkg, mlc_front, mlc_log_pipe and mlc_scale.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_level): one level d per transaction,
//    unsigned Q1.FRAC_BITS; anything above 1.0 is treated as 1.0.
//  - Output channel (out_valid/out_ready/out_compressed): one result per input,
//    unsigned Q1.FRAC_BITS, saturated to 1.0, in input order.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 = mu,
//    index 1 = norm_scale (1/log2(1+mu), Q1.16). Other indexes are dropped.
//    Write only while the pipeline is empty; registers feed stages live.
//  - Pipeline: 2 front stages (multiply, normalize), one squaring stage per
//    fraction bit, 2 back stages (scale multiply, saturate/output register).
//  - Throughput: one transaction per clock while out_ready is high. Every stage
//    takes a new item when it is empty or its successor moves, so bubbles close
//    up and the squaring chain (one 31x31 multiply per stage) sets the clock.
//  - Stall: if out_ready stays low, the output register holds its result and
//    the stages behind it keep filling; in_ready drops only once all are full.
//  - Reset (rst_n low, synchronous): pipeline emptied, mu = 255,
//    norm_scale = 8192; in_ready and cfg_ready are held low during reset.
module mu_law_compressor_core import mlc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FRAC_BITS:0]      in_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS:0]      out_compressed,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [NORM_W-1:0]       cfg_data
);

  logic [MU_W-1:0]       mu_r;
  logic [NORM_W-1:0]     norm_r;

  logic                  front_ready;
  logic                  front_valid;
  logic [IPART_W-1:0]    front_ipart;
  logic [MANT_BITS:0]    front_mant;

  logic                  log_ready;
  logic                  log_valid;
  logic [IPART_W-1:0]    log_ipart;
  logic [FRAC_BITS-1:0]  log_frac;

  logic                  scale_ready;

  // Config registers; always ready outside reset
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r   <= MU_RST;
      norm_r <= NORM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MU:         mu_r   <= cfg_data[MU_W-1:0];
        CFG_NORM_SCALE: norm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // No transaction is taken at a reset edge
  assign in_ready = rst_n && front_ready;

  mlc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid && rst_n),
    .ready_o (front_ready),
    .level_i (in_level),
    .mu_i    (mu_r),
    .valid_o (front_valid),
    .ready_i (log_ready),
    .ipart_o (front_ipart),
    .mant_o  (front_mant)
  );

  mlc_log_pipe #(.FRAC_BITS(FRAC_BITS)) u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_valid),
    .ready_o (log_ready),
    .ipart_i (front_ipart),
    .mant_i  (front_mant),
    .valid_o (log_valid),
    .ready_i (scale_ready),
    .ipart_o (log_ipart),
    .frac_o  (log_frac)
  );

  mlc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (log_valid),
    .ready_o  (scale_ready),
    .ipart_i  (log_ipart),
    .frac_i   (log_frac),
    .norm_i   (norm_r),
    .valid_o  (out_valid),
    .ready_i  (out_ready),
    .result_o (out_compressed)
  );

endmodule

/* rtl/mlc_checker.sv */
// mlc_checker: port-level assertions for mu_law_compressor_core, bound to the top.
// Depends on mlc_pkg and mu_law_compressor_core.
module mlc_checker import mlc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [FRAC_BITS:0]   out_compressed
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_compressed))
    else $error("output changed while stalled");

  // Result never exceeds 1.0
  a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_compressed <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
    else $error("result above 1.0");

  // Backpressure only when the whole pipe is full, output included
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with pipeline not full");

  // Leaving reset: empty pipeline, ready to take data
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> in_ready && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

bind mu_law_compressor_core mlc_checker #(.FRAC_BITS(FRAC_BITS)) u_mlc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_compressed (out_compressed)
);

/* tb/tb_mu_law_compressor_core.sv */
// tb_mu_law_compressor_core: self-checking testbench for the mu-law compressor core.
// Depends on mlc_pkg and mu_law_compressor_core; an in-bench predictor gives the
// expected result of every accepted level.
module tb_mu_law_compressor_core;
  import mlc_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int LW          = FB + 1;          // level / result width
  localparam int DRAIN_CYC   = FB + 10;         // pipeline latency plus margin
  localparam int STALL_LIMIT = 2000;            // cycles without any transaction
  localparam int IDLE_PCT    = 27;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [LW-1:0]        in_level;
  logic                 out_valid;
  logic                 out_ready;
  logic [LW-1:0]        out_compressed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NORM_W-1:0]    cfg_data;

  // Level in flight together with the result it must produce.
  typedef struct packed {
    logic [LW-1:0] level;
    logic [LW-1:0] compressed;
  } owed_result_t;

  owed_result_t      owed_results[$];
  logic [MU_W-1:0]   mu_shadow;
  logic [NORM_W-1:0] norm_shadow;
  bit                idling;       // random gaps on both channels when set
  int                errors;
  int                quiet_cycles;

  mu_law_compressor_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_level      (in_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_compressed(out_compressed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // log2 of a (Q.FB, a >= 1.0) as unsigned Q.FB. Integer part from the leading
  // one; fraction from FB squarings of a Q1.30 mantissa, each truncated.
  function automatic logic [63:0] log2_q(logic [63:0] a);
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] ipart;
    int          p;
    p = 0;
    while (p < 63 && (a >> (p + 1)) != 0) p++;
    if (p >= MANT_BITS) m = a >> (p - MANT_BITS);
    else                m = a << (MANT_BITS - p);
    frac = 0;
    repeat (FB) begin
      m    = (m * m) >> MANT_BITS;
      frac = frac << 1;
      // square reached 2.0: halve and emit a one
      if (m >= (64'd2 << MANT_BITS)) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    ipart = p - FB;
    return (ipart << FB) | frac;
  endfunction

  // Expected compressed level for one input under the given register values.
  function automatic logic [LW-1:0] mu_law_predict(logic [LW-1:0] level,
                                                   logic [MU_W-1:0] mu_v,
                                                   logic [NORM_W-1:0] scale);
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] y;
    logic [63:0] one_q;
    one_q = 64'd1 << FB;
    d = level;
    if (d > one_q) d = one_q;           // levels above 1.0 clip to 1.0
    a = mu_v;
    a = one_q + a * d;                  // exact 1 + mu*d
    y = (log2_q(a) * scale) >> SCALE_BITS;
    if (y > one_q) y = one_q;           // result saturates to 1.0
    return y[LW-1:0];
  endfunction

  // Norm scale matched to mu: 1/log2(1+mu) in Q1.16.
  function automatic logic [NORM_W-1:0] matched_norm(logic [MU_W-1:0] mu_v);
    logic [63:0] a;
    logic [63:0] q;
    a = mu_v;
    a = (a + 1) << FB;
    q = (64'd1 << (FB + SCALE_BITS)) / log2_q(a);
    if (q > 64'h1FFFF) q = 64'h1FFFF;
    return q[NORM_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered and left at a falling edge at which they
  // assigned nothing, so no signal sees two assignments in one time step.
  // ---------------------------------------------------------------------------

  // One input transaction; valid stays high into the next call when no gap.
  task automatic send_level(input logic [LW-1:0] level);
    // each idle cycle drawn on its own, so about IDLE_PCT of cycles are gaps
    while (idling && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_results.push_back('{level: level,
                             compressed: mu_law_predict(level, mu_shadow, norm_shadow)});
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write; only called with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [NORM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_MU:         mu_shadow   = data[MU_W-1:0];
      CFG_NORM_SCALE: norm_shadow = data;
      default: ;      // undecoded index, dropped by the block
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [LW-1:0] rand_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 17'd65536;
      2:       return $urandom_range(65537, 131071);   // clips to 1.0
      3:       return $urandom_range(0, 255);
      4:       return 17'd1 << $urandom_range(0, FB);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of mu and norm_scale, level extremes and clipping.
  task automatic test_reset_config();
    send_level(17'd0);
    send_level(17'd1);
    send_level(17'd32768);
    send_level(17'd65535);
    send_level(17'd65536);
    send_level(17'd65537);
    send_level(17'h1FFFF);
    drain_pipe();
  endtask

  // Register extremes, mu zero, out-of-range norm_scale, undecoded indexes.
  task automatic test_register_edges();
    write_reg(CFG_MU, 17'd1);
    write_reg(CFG_NORM_SCALE, 17'd65536);
    send_level(17'd65536);
    send_level(17'd1);
    send_level(17'h0AAAA);
    drain_pipe();
    write_reg(CFG_MU, 17'd65535);
    write_reg(CFG_NORM_SCALE, 17'd4096);
    send_level(17'd1);
    send_level(17'd65536);
    send_level(17'h15555);
    drain_pipe();
    // bit 16 of the data is dropped for mu, so this writes mu = 0
    write_reg(CFG_MU, 17'h10000);
    send_level(17'd65536);
    send_level(17'd40000);
    drain_pipe();
    // undecoded indexes must leave both registers alone
    write_reg(CFG_UNUSED_2, 17'd7);
    write_reg(CFG_UNUSED_3, 17'h1FFFF);
    send_level(17'd12345);
    drain_pipe();
    // oversized scale pushes results into saturation
    write_reg(CFG_MU, 17'd255);
    write_reg(CFG_NORM_SCALE, 17'h1FFFF);
    send_level(17'd65536);
    send_level(17'd300);
    drain_pipe();
    write_reg(CFG_NORM_SCALE, 17'd0);
    send_level(17'd65536);
    drain_pipe();
  endtask

  // Random configuration phases with random levels and gaps on both sides.
  task automatic test_random_phases(input int phases, input int per_phase);
    logic [NORM_W-1:0] mu_data;
    logic [NORM_W-1:0] norm_data;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(5))
        0:       mu_data = 17'd1;
        1:       mu_data = 17'd65535;
        2:       mu_data = $urandom_range(1, 1000);
        default: mu_data = $urandom_range(1, 65535);
      endcase
      if ($urandom_range(3) == 0) mu_data[16] = 1'b1;   // ignored bit
      if ($urandom_range(3) == 0) norm_data = $urandom_range(0, 131071);
      else                        norm_data = matched_norm(mu_data[MU_W-1:0]);
      write_reg(CFG_MU, mu_data);
      write_reg(CFG_NORM_SCALE, norm_data);
      repeat (per_phase) send_level(rand_level());
      drain_pipe();
    end
  endtask

  // Back-to-back traffic with no idling anywhere, at the reset-like setting.
  task automatic test_full_rate(input int count);
    idling = 1'b0;
    write_reg(CFG_MU, 17'd255);
    write_reg(CFG_NORM_SCALE, matched_norm(16'd255));
    repeat (count) send_level(rand_level());
    drain_pipe();
    idling = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, and each result checked against the
  // oldest owed one.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ready <= !idling || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    owed_result_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, out_compressed);
        errors++;
      end else begin
        owed = owed_results.pop_front();
        if (out_compressed !== owed.compressed) begin
          $display("%0t: compressed mismatch for level %0d, expected %0d, got %0d",
                   $time, owed.level, owed.compressed, out_compressed);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_level     = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MU;
    cfg_data     = '0;
    mu_shadow    = MU_RST;
    norm_shadow  = NORM_RST;
    idling       = 1'b1;
    errors       = 0;
    quiet_cycles = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_config();
    test_register_edges();
    test_random_phases(7, 150);
    test_full_rate(200);

    // nothing owed any more; let the pipeline run dry to catch stray results
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
